@@ src/shadow_map_pcf_sampler_unit_macros.svh @@
// Assertion macros for the shadow map PCF sampler.
// Used by the top level; relies on i_clk and i_rst_n in the including module.
`ifndef SHADOW_MAP_PCF_SAMPLER_UNIT_MACROS_SVH
`define SHADOW_MAP_PCF_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define SMPCF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SMPCF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/smpcf_pkg.sv @@
// Shared constants and codes for the shadow map PCF sampler.
// No dependencies.
package smpcf_pkg;

    localparam int MAX_SIDE_DEF   = 64;
    localparam int FACE_COUNT_DEF = 6;
    localparam int MAX_KERNEL_DEF = 8;
    localparam int DEPTH_BITS_DEF = 24;
    localparam int DISK_TAPS      = 4;
    localparam int TAP_W          = 2;

    localparam int OP_W     = 3;
    localparam int FACE_W   = 3;
    localparam int COORD_W  = 18;
    localparam int DEPTH_W  = 24;
    localparam int TEXEL_W  = 6;
    localparam int VIS_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int OFF_W    = 25;

    localparam logic [OP_W-1:0] OP_LOAD    = 3'd0;
    localparam logic [OP_W-1:0] OP_HARD    = 3'd1;
    localparam logic [OP_W-1:0] OP_PCF     = 3'd2;
    localparam logic [OP_W-1:0] OP_POISSON = 3'd3;
    localparam logic [OP_W-1:0] OP_PPCF    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 2'd2;

    // Poisson disk offsets / 700 in Q32
    localparam logic signed [OFF_W-1:0] DISK_DX [DISK_TAPS] = '{
        -25'sd5779898, 25'sd5801802, -25'sd577882, 25'sd2116556};
    localparam logic signed [OFF_W-1:0] DISK_DY [DISK_TAPS] = '{
        -25'sd2448513, -25'sd4717759, -25'sd5702420, 25'sd1803135};

endpackage

@@ src/shadow_map_pcf_sampler_unit.sv @@
// Top level of the shadow map PCF sampler: sequencer, config registers.
// Depends on smpcf_pkg, smpcf_mem, smpcf_tex, smpcf_div and the macro header.
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries loads and queries; the
//   output channel (o_out_valid / i_out_stall) returns one visibility word for
//   every input transfer, loads and ignored items included (value 0).
//   Config writes (i_cfg_we, i_cfg_index, i_cfg_data) are taken at any edge
//   and must only be issued while the block is idle.
// Sequencing
//   A load or an ignored item skips the tap sequence. A query runs, per tap,
//   the texel index steps and the window reads through the single memory read
//   port, then a 1-bit-per-cycle divide of NUM_W steps. One item is in flight
//   at a time; the index multiplier is shared across all taps, and the divider
//   runs once per query.
// Reset
//   Synchronous, active low. Control and config registers take their reset
//   values; map contents are undefined until written. No clearing pass.
// Stall
//   The output register holds its result while i_out_stall is high; a newly
//   finished result waits in r_res, input stalled, until that register frees.
`include "shadow_map_pcf_sampler_unit_macros.svh"
module shadow_map_pcf_sampler_unit #(
    parameter int MAX_SIDE   = smpcf_pkg::MAX_SIDE_DEF,
    parameter int FACE_COUNT = smpcf_pkg::FACE_COUNT_DEF,
    parameter int MAX_KERNEL = smpcf_pkg::MAX_KERNEL_DEF,
    parameter int DEPTH_BITS = smpcf_pkg::DEPTH_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [smpcf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smpcf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [smpcf_pkg::OP_W-1:0]           i_operation,
    input  logic [smpcf_pkg::FACE_W-1:0]         i_face,
    input  logic signed [smpcf_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [smpcf_pkg::COORD_W-1:0] i_coord_y,
    input  logic [smpcf_pkg::DEPTH_W-1:0]        i_depth_value,
    input  logic [smpcf_pkg::TEXEL_W-1:0]        i_texel_col,
    input  logic [smpcf_pkg::TEXEL_W-1:0]        i_texel_row,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [smpcf_pkg::VIS_W-1:0]          o_visibility
);
    import smpcf_pkg::*;

    localparam int FACE_WORDS = MAX_SIDE * MAX_SIDE;
    localparam int MEM_DEPTH  = FACE_COUNT * FACE_WORDS;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int SZ_W       = $clog2(MAX_SIDE + 1);
    localparam int IDX_W      = $clog2(MAX_SIDE);
    localparam int KW         = $clog2(MAX_KERNEL + 1);
    localparam int TX_W       = SZ_W + 5;
    localparam int CNT_MAX    = DISK_TAPS * MAX_KERNEL * MAX_KERNEL;
    localparam int CNT_W      = $clog2(CNT_MAX + 1);
    localparam int NUM_W      = CNT_W + 16;
    localparam int DEN_W      = 2 * KW;

    typedef enum logic [2:0] {
        S_IDLE, S_TEXX, S_TEXY, S_WSET, S_WIN, S_DRAIN, S_DIVGO, S_DIV
    } t_state;

    t_state r_state;
    logic   r_fin;

    // Config registers, raw
    logic [CFG_DATA_W-1:0] r_map_w;
    logic [CFG_DATA_W-1:0] r_map_h;
    logic [3:0]            r_kern;

    // Query context
    logic [FACE_W-1:0]        r_face;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic [DEPTH_BITS-1:0]    r_ref;
    logic                     r_pcf;
    logic                     r_poisson;
    logic [TAP_W-1:0]         r_tap;
    logic signed [TX_W-1:0]   r_tx;
    logic [SZ_W-1:0]          r_x1;
    logic [SZ_W-1:0]          r_y1;
    logic [KW-1:0]            r_i;
    logic [KW-1:0]            r_j;
    logic                     r_pend;
    logic [CNT_W-1:0]         r_count;
    logic [VIS_W-1:0]         r_res;
    logic                     r_out_valid;
    logic [VIS_W-1:0]         r_vis;

    // Saturated sizes
    logic [SZ_W-1:0] w_sat;
    logic [SZ_W-1:0] h_sat;
    logic [KW-1:0]   k_sat;
    logic [KW-1:0]   k_eff;

    always_comb begin
        if (r_map_w == '0) w_sat = SZ_W'(1);
        else if (32'(r_map_w) > MAX_SIDE) w_sat = SZ_W'(MAX_SIDE);
        else w_sat = SZ_W'(r_map_w);
        if (r_map_h == '0) h_sat = SZ_W'(1);
        else if (32'(r_map_h) > MAX_SIDE) h_sat = SZ_W'(MAX_SIDE);
        else h_sat = SZ_W'(r_map_h);
        if (r_kern == '0) k_sat = KW'(1);
        else if (32'(r_kern) > MAX_KERNEL) k_sat = KW'(MAX_KERNEL);
        else k_sat = KW'(r_kern);
        // Hard and Poisson compares use a one-texel window
        k_eff = r_pcf ? k_sat : KW'(1);
    end

    // Shared texel index unit: x in TEXX, y in TEXY
    logic signed [COORD_W-1:0] tex_coord;
    logic signed [OFF_W-1:0]   tex_off;
    logic [SZ_W-1:0]           tex_size;
    logic signed [TX_W-1:0]    tex_tx;

    always_comb begin
        if (r_state == S_TEXX) begin
            tex_coord = r_cx;
            tex_off   = r_poisson ? DISK_DX[r_tap] : '0;
            tex_size  = w_sat;
        end else begin
            tex_coord = r_cy;
            tex_off   = r_poisson ? DISK_DY[r_tap] : '0;
            tex_size  = h_sat;
        end
    end

    smpcf_tex #(.SZ_W(SZ_W), .TX_W(TX_W)) u_tex (
        .i_coord (tex_coord),
        .i_off   (tex_off),
        .i_size  (tex_size),
        .o_tx    (tex_tx)
    );

    // Window start: index - k/2, clamped into 0..size-k, then at least 0
    logic [SZ_W-1:0]        clamp_size;
    logic signed [TX_W-1:0] win_hi;
    logic signed [TX_W-1:0] win_v;
    logic [SZ_W-1:0]        win_start;

    always_comb begin
        clamp_size = (r_state == S_TEXY) ? w_sat : h_sat;
        win_hi = $signed(TX_W'(clamp_size)) - $signed(TX_W'(k_eff));
        win_v  = r_tx - $signed(TX_W'(k_eff >> 1));
        if (win_v > win_hi) win_v = win_hi;
        if (win_v < 0) win_v = '0;
        win_start = SZ_W'(win_v);
    end

    // Window read address, edge texels repeat past the map border
    logic [SZ_W:0]      col_sum;
    logic [SZ_W:0]      row_sum;
    logic [IDX_W-1:0]   rd_col;
    logic [IDX_W-1:0]   rd_row;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;

    always_comb begin
        col_sum = {1'b0, r_x1} + (SZ_W+1)'(r_i);
        row_sum = {1'b0, r_y1} + (SZ_W+1)'(r_j);
        if (col_sum > (SZ_W+1)'(w_sat - 1'b1)) rd_col = IDX_W'(w_sat - 1'b1);
        else rd_col = IDX_W'(col_sum);
        if (row_sum > (SZ_W+1)'(h_sat - 1'b1)) rd_row = IDX_W'(h_sat - 1'b1);
        else rd_row = IDX_W'(row_sum);
        rd_addr = ADDR_W'(r_face) * ADDR_W'(FACE_WORDS)
                + ADDR_W'(rd_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(rd_col);
        rd_en   = (r_state == S_WIN);
    end

    // Load write port
    logic              in_xfer;
    logic              face_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    always_comb begin
        in_xfer = i_in_valid && !o_in_stall;
        face_ok = 32'(i_face) < FACE_COUNT;
        wr_en   = in_xfer && (i_operation == OP_LOAD) && face_ok
                && (32'(i_texel_col) < MAX_SIDE) && (32'(i_texel_row) < MAX_SIDE);
        wr_addr = ADDR_W'(i_face) * ADDR_W'(FACE_WORDS)
                + ADDR_W'(i_texel_row) * ADDR_W'(MAX_SIDE) + ADDR_W'(i_texel_col);
    end

    logic [DEPTH_BITS-1:0] rd_data;

    smpcf_mem #(.DEPTH(MEM_DEPTH), .DATA_W(DEPTH_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (DEPTH_BITS'(i_depth_value)),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Divider: count * 2^16 / (taps * k * k); taps of four fold into the shift
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;

    always_comb begin
        div_start = (r_state == S_DIVGO);
        div_num   = r_poisson ? (NUM_W'(r_count) << 14) : (NUM_W'(r_count) << 16);
        div_den   = DEN_W'(k_eff) * DEN_W'(k_eff);
    end

    smpcf_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= CFG_DATA_W'(64);
            r_map_h <= CFG_DATA_W'(64);
            r_kern  <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:   r_map_w <= i_cfg_data;
                CFG_MAP_HEIGHT:  r_map_h <= i_cfg_data;
                CFG_KERNEL_SIZE: r_kern  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic last_i;
    logic last_j;
    logic last_tap;
    logic out_free;

    always_comb begin
        last_i   = (r_i == k_eff - 1'b1);
        last_j   = (r_j == k_eff - 1'b1);
        last_tap = !r_poisson || (r_tap == TAP_W'(DISK_TAPS - 1));
        out_free = !r_out_valid || !i_out_stall;
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= 1'b0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the output transfer unless a new result refills the register
            if (r_out_valid && !i_out_stall && !r_fin) begin
                r_out_valid <= 1'b0;
            end
            // Score the texel read issued last cycle
            r_pend <= rd_en;
            if (r_pend && (rd_data >= r_ref)) begin
                r_count <= r_count + 1'b1;
            end
            if (r_fin) begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    r_out_valid <= 1'b1;
                    r_vis       <= r_res;
                    r_fin       <= 1'b0;
                end
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (in_xfer) begin
                            r_face    <= i_face;
                            r_cx      <= i_coord_x;
                            r_cy      <= i_coord_y;
                            r_ref     <= DEPTH_BITS'(i_depth_value);
                            r_pcf     <= (i_operation == OP_PCF) || (i_operation == OP_PPCF);
                            r_poisson <= (i_operation == OP_POISSON)
                                      || (i_operation == OP_PPCF);
                            r_tap     <= '0;
                            r_count   <= '0;
                            r_res     <= '0;
                            if (face_ok && (i_operation == OP_HARD || i_operation == OP_PCF
                                    || i_operation == OP_POISSON || i_operation == OP_PPCF)) begin
                                r_state <= S_TEXX;
                            end else begin
                                r_fin <= 1'b1;
                            end
                        end
                    end
                    S_TEXX: begin
                        r_tx    <= tex_tx;
                        r_state <= S_TEXY;
                    end
                    S_TEXY: begin
                        r_x1    <= win_start;
                        r_tx    <= tex_tx;
                        r_state <= S_WSET;
                    end
                    S_WSET: begin
                        r_y1    <= win_start;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_WIN;
                    end
                    S_WIN: begin
                        if (last_i) begin
                            r_i <= '0;
                            if (last_j) begin
                                if (last_tap) begin
                                    r_state <= S_DRAIN;
                                end else begin
                                    r_tap   <= r_tap + 1'b1;
                                    r_state <= S_TEXX;
                                end
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                    S_DRAIN: r_state <= S_DIVGO;
                    S_DIVGO: r_state <= S_DIV;
                    S_DIV: begin
                        if (div_done) begin
                            r_res   <= div_quo[VIS_W-1:0];
                            r_fin   <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    assign o_in_stall   = (r_state != S_IDLE) || r_fin;
    assign o_out_valid  = r_out_valid;
    assign o_visibility = r_vis;

    `SMPCF_ASSERT_NEXT(a_win_scores, r_state == S_WIN, r_pend, "window read not scored")
    `SMPCF_ASSERT_NOW(a_count_max, 1'b1, 32'(r_count) <= CNT_MAX, "pass count overflow")
    `SMPCF_ASSERT_NOW(a_div_owner, div_done, r_state == S_DIV, "divider done out of turn")
    `SMPCF_ASSERT_NOW(a_out_src, $rose(r_out_valid), $past(r_fin), "result without finish")
endmodule

@@ src/smpcf_mem.sv @@
// Depth map storage: one write port, one registered read port.
// Depends on nothing but its parameters.
module smpcf_mem #(
    parameter int DEPTH  = 24576,
    parameter int DATA_W = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/smpcf_tex.sv @@
// Texel index unit: round((coord + offset) * size) toward zero after +0.5.
// Depends on smpcf_pkg.
module smpcf_tex #(
    parameter int SZ_W = 7,
    parameter int TX_W = 12
) (
    input  logic signed [smpcf_pkg::COORD_W-1:0] i_coord,
    input  logic signed [smpcf_pkg::OFF_W-1:0]   i_off,
    input  logic        [SZ_W-1:0]               i_size,
    output logic signed [TX_W-1:0]               o_tx
);
    import smpcf_pkg::*;
    localparam int S_W = 35;
    localparam int P_W = S_W + SZ_W + 1;

    logic signed [S_W-1:0] sum;
    logic signed [P_W-1:0] prod;
    logic signed [P_W-1:0] p;
    logic signed [P_W-1:0] pn;
    logic signed [TX_W-1:0] tpos;
    logic signed [TX_W-1:0] tneg;

    always_comb begin
        sum  = S_W'($signed({i_coord, 16'b0})) + S_W'(i_off);
        prod = P_W'(sum) * $signed({1'b0, i_size});
        p    = prod + $signed(P_W'(64'h8000_0000));
        pn   = -p;
        tpos = TX_W'(p >>> 32);
        tneg = -TX_W'($signed({1'b0, pn[P_W-1:32]}));
        o_tx = p[P_W-1] ? tneg : tpos;
    end
endmodule

@@ src/smpcf_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module smpcf_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = ge ? (trial - {1'b0, r_den}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_rem  <= '0;
                r_den  <= i_den;
                r_quo  <= i_num;
            end else if (r_busy) begin
                r_rem <= diff[DEN_W-1:0];
                r_quo <= {r_quo[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

@@ dv/shadow_map_pcf_sampler_unit_tb.sv @@
// Self-checking testbench for shadow_map_pcf_sampler_unit.
// Depends on smpcf_pkg and the RTL. Every texel that a query can reach is
// loaded first; directed and random loads and queries follow over several
// register settings. An in-bench predictor computes each word not typed in.
`timescale 1ns / 100ps
module shadow_map_pcf_sampler_unit_tb;
    import smpcf_pkg::*;

    // Spare operation codes: the block must answer 0 and do nothing
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int SIDE       = MAX_SIDE_DEF;
    localparam int FACE_TEXELS = SIDE * SIDE;
    // Square corner of every face that small maps read; row 0 and column 0
    // are loaded in full for the long thin maps
    localparam int CORNER       = 8;
    localparam int RANDOM_ITEMS = 870;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam logic [VIS_W-1:0] VIS_ONE = 17'd65536;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [FACE_W-1:0]         face;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [DEPTH_W-1:0]        depth;
        logic [TEXEL_W-1:0]        col;
        logic [TEXEL_W-1:0]        row;
    } t_sample_req;

    // One directed row: the request, and a typed-in visibility where obvious
    typedef struct packed {
        t_sample_req      req;
        logic             fixed;
        logic [VIS_W-1:0] vis;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_operation;
    logic [FACE_W-1:0]     i_face;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic [DEPTH_W-1:0]    i_depth_value;
    logic [TEXEL_W-1:0]    i_texel_col;
    logic [TEXEL_W-1:0]    i_texel_row;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [VIS_W-1:0]      o_visibility;

    shadow_map_pcf_sampler_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_face(i_face),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y),
        .i_depth_value(i_depth_value),
        .i_texel_col(i_texel_col), .i_texel_row(i_texel_row),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_visibility(o_visibility)
    );

    // Shadow copy of the block: maps and registers as last written
    logic [DEPTH_W-1:0]    shadow_texels [FACE_COUNT_DEF * FACE_TEXELS];
    logic [CFG_DATA_W-1:0] shadow_width;
    logic [CFG_DATA_W-1:0] shadow_height;
    logic [CFG_DATA_W-1:0] shadow_kernel;

    logic [VIS_W-1:0] vis_pending [$];
    int  mismatch_count;
    int  results_seen;
    int  queries_sent;
    int  cycle_count;
    bit  calm;          // no idling on either side while set
    bit  hold_request;  // asks the receiver for one long stall
    int  hold_left;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, vis_pending.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [VIS_W-1:0] got,
                                   input logic [VIS_W-1:0] want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Saturate a register value into lo..hi
    function automatic int clip_reg(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Scale a Q16 point plus Q32 offset by the map size, round half up, truncate to zero
    function automatic longint texel_index(input longint coord, input longint off,
                                           input int size);
        longint p;
        p = (coord * 65536 + off) * size + (64'sd1 <<< 31);
        if (p >= 0)
            return p >>> 32;
        return -((-p) >>> 32);
    endfunction

    function automatic int lit_at(input int face, input longint col, input longint row,
                                  input int w, input int h, input logic [DEPTH_W-1:0] ref_depth);
        longint c;
        longint r;
        c = col > w - 1 ? w - 1 : col;
        c = c < 0 ? 0 : c;
        r = row > h - 1 ? h - 1 : row;
        r = r < 0 ? 0 : r;
        return shadow_texels[face * FACE_TEXELS + int'(r) * SIDE + int'(c)] >= ref_depth;
    endfunction

    function automatic int window_lit(input int face, input longint cx, input longint cy,
                                      input longint ox, input longint oy, input int w,
                                      input int h, input int k,
                                      input logic [DEPTH_W-1:0] ref_depth);
        longint x0;
        longint y0;
        int n;
        n = 0;
        x0 = texel_index(cx, ox, w) - k / 2;
        y0 = texel_index(cy, oy, h) - k / 2;
        if (x0 > w - k) x0 = w - k;
        if (y0 > h - k) y0 = h - k;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        for (int i = 0; i < k; i++)
            for (int j = 0; j < k; j++)
                n += lit_at(face, x0 + i, y0 + j, w, h, ref_depth);
        return n;
    endfunction

    // Visibility of one request; a load updates the shadow maps
    function automatic logic [VIS_W-1:0] predict_visibility(input t_sample_req q);
        int w;
        int h;
        int k;
        longint lit;
        longint samples;
        longint cx;
        longint cy;
        w = clip_reg(shadow_width, 1, SIDE);
        h = clip_reg(shadow_height, 1, SIDE);
        k = clip_reg(shadow_kernel, 1, MAX_KERNEL_DEF);
        cx = q.cx;
        cy = q.cy;
        lit = 0;
        samples = 1;
        if (q.face >= FACE_COUNT_DEF || q.op > OP_PPCF)
            return '0;
        case (q.op)
            OP_LOAD: begin
                shadow_texels[q.face * FACE_TEXELS + q.row * SIDE + q.col] = q.depth;
                return '0;
            end
            OP_HARD: begin
                lit = lit_at(q.face, texel_index(cx, 0, w), texel_index(cy, 0, h), w, h,
                             q.depth);
            end
            OP_PCF: begin
                lit = window_lit(q.face, cx, cy, 0, 0, w, h, k, q.depth);
                samples = k * k;
            end
            OP_POISSON: begin
                for (int t = 0; t < DISK_TAPS; t++)
                    lit += lit_at(q.face, texel_index(cx, DISK_DX[t], w),
                                  texel_index(cy, DISK_DY[t], h), w, h, q.depth);
                samples = DISK_TAPS;
            end
            default: begin
                for (int t = 0; t < DISK_TAPS; t++)
                    lit += window_lit(q.face, cx, cy, DISK_DX[t], DISK_DY[t], w, h, k,
                                      q.depth);
                samples = DISK_TAPS * k * k;
            end
        endcase
        return VIS_W'((lit * 65536) / samples);
    endfunction

    // Checker and receiver stall: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (vis_pending.size() == 0)
                report_mismatch("unexpected result", o_visibility, '0);
            else if (o_visibility !== vis_pending[0]) begin
                report_mismatch("visibility", o_visibility, vis_pending[0]);
                void'(vis_pending.pop_front());
            end else
                void'(vis_pending.pop_front());
        end
        // A hold request starts one long stall so the block backs up onto its input
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 1500;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 10);
        end
    end

    // Offer one request and hold it until the transfer happens
    task automatic send_request(input t_sample_req q, input bit fixed,
                                input logic [VIS_W-1:0] fixed_vis);
        logic [VIS_W-1:0] want;
        if (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= q.op;
        i_face        <= q.face;
        i_coord_x     <= q.cx;
        i_coord_y     <= q.cy;
        i_depth_value <= q.depth;
        i_texel_col   <= q.col;
        i_texel_row   <= q.row;
        do
            @(posedge i_clk);
        while (o_in_stall);
        want = predict_visibility(q);
        vis_pending.push_back(fixed ? fixed_vis : want);
        if (q.op != OP_LOAD)
            queries_sent++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        while (vis_pending.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAP_WIDTH:   shadow_width  = val;
            CFG_MAP_HEIGHT:  shadow_height = val;
            CFG_KERNEL_SIZE: shadow_kernel = {3'b000, val[3:0]};
            default: ;
        endcase
    endtask

    // Mostly points near the map, now and then anything the field holds
    function automatic logic signed [COORD_W-1:0] pick_coord;
        if ($urandom_range(0, 9) == 0)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 104857)) - 19661);
    endfunction

    function automatic t_sample_req pick_request;
        t_sample_req q;
        int pick;
        q.face  = FACE_W'($urandom_range(0, FACE_COUNT_DEF - 1));
        q.cx    = pick_coord();
        q.cy    = pick_coord();
        q.depth = DEPTH_W'($urandom);
        q.col   = TEXEL_W'($urandom);
        q.row   = TEXEL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
            q.op = OP_LOAD;
        else if (pick < 47)
            q.op = OP_HARD;
        else if (pick < 64)
            q.op = OP_PCF;
        else if (pick < 81)
            q.op = OP_POISSON;
        else if (pick < 97)
            q.op = OP_PPCF;
        else if (pick < 98)
            q.op = OP_SPARE_5 + OP_W'($urandom_range(0, 2));
        else begin
            q.op = OP_W'($urandom_range(0, 4));
            q.face = FACE_W'($urandom_range(FACE_COUNT_DEF, 7));
        end
        return q;
    endfunction

    function automatic t_sample_req make_req(input logic [OP_W-1:0] op,
                                             input logic [FACE_W-1:0] face,
                                             input int cx, input int cy,
                                             input logic [DEPTH_W-1:0] depth,
                                             input int col, input int row);
        t_sample_req q;
        q.op = op;
        q.face = face;
        q.cx = COORD_W'(cx);
        q.cy = COORD_W'(cy);
        q.depth = depth;
        q.col = TEXEL_W'(col);
        q.row = TEXEL_W'(row);
        return q;
    endfunction

    initial begin
        t_directed_row rows [$];
        // Register settings per random phase: width, height, kernel.
        // Zero and all-ones check saturation on the thin maps; 5x3 with
        // kernel 8 overhangs the map.
        logic [CFG_DATA_W-1:0] phase_cfg [8][3] = '{
            '{7'd8, 7'd8, 7'd3}, '{7'd1, 7'd1, 7'd1}, '{7'd8, 7'd8, 7'd8},
            '{7'd5, 7'd3, 7'd8}, '{7'd0, 7'd127, 7'd0}, '{7'd127, 7'd0, 7'd15},
            '{7'd7, 7'd6, 7'd4}, '{7'd8, 7'd2, 7'd7}};
        int per_phase;

        mismatch_count = 0;
        results_seen = 0;
        queries_sent = 0;
        cycle_count = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        hold_left = 0;
        shadow_width = 7'd64;
        shadow_height = 7'd64;
        shadow_kernel = 7'd3;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_operation = OP_LOAD;
        i_face = '0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_depth_value = '0;
        i_texel_col = '0;
        i_texel_row = '0;
        i_out_stall = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Items that touch no texel, before any load: ignored faces and spare codes
        send_request(make_req(OP_HARD, 3'd6, 0, 0, 24'd0, 0, 0), 1'b1, '0);
        send_request(make_req(OP_LOAD, 3'd7, 0, 0, 24'hFFFFFF, 63, 63), 1'b1, '0);
        send_request(make_req(OP_SPARE_7, 3'd0, 0, 0, 24'd0, 0, 0), 1'b1, '0);
        drain();

        // Queries from here on stay inside the loaded texels
        write_reg(CFG_MAP_WIDTH, 7'd8);
        write_reg(CFG_MAP_HEIGHT, 7'd8);

        // Load the corner, row 0 and column 0 of every face
        for (int f = 0; f < FACE_COUNT_DEF; f++)
            for (int r = 0; r < SIDE; r++)
                for (int c = 0; c < SIDE; c++)
                    if ((r < CORNER && c < CORNER) || r == 0 || c == 0)
                        send_request(make_req(OP_LOAD, FACE_W'(f), 0, 0, DEPTH_W'($urandom),
                                              c, r), 1'b1, '0);

        // Directed part on 8x8 maps, kernel 3
        rows.push_back('{make_req(OP_LOAD, 3'd0, 0, 0, 24'hFFFFFF, 0, 0), 1'b1, '0});
        rows.push_back('{make_req(OP_LOAD, 3'd5, 0, 0, 24'd0, 63, 63), 1'b1, '0});
        rows.push_back('{make_req(OP_LOAD, 3'd6, 0, 0, 24'h123456, 1, 1), 1'b1, '0});
        rows.push_back('{make_req(OP_SPARE_5, 3'd1, 32768, 32768, 24'd0, 0, 0), 1'b1, '0});
        rows.push_back('{make_req(OP_SPARE_6, 3'd2, 32768, 32768, 24'd0, 0, 0), 1'b1, '0});
        rows.push_back('{make_req(OP_HARD, 3'd7, 32768, 32768, 24'd0, 0, 0), 1'b1, '0});
        rows.push_back('{make_req(OP_PPCF, 3'd6, 32768, 32768, 24'd0, 0, 0), 1'b1, '0});
        // Reference depth 0: every texel passes
        rows.push_back('{make_req(OP_HARD, 3'd2, 32768, 32768, 24'd0, 0, 0), 1'b1, VIS_ONE});
        rows.push_back('{make_req(OP_PCF, 3'd3, 1000, 60000, 24'd0, 0, 0), 1'b1, VIS_ONE});
        rows.push_back('{make_req(OP_POISSON, 3'd4, 5, 9, 24'd0, 0, 0), 1'b1, VIS_ONE});
        rows.push_back('{make_req(OP_PPCF, 3'd5, 65535, 0, 24'd0, 0, 0), 1'b1, VIS_ONE});
        // Corner texel of face 0 now holds the maximum depth
        rows.push_back('{make_req(OP_HARD, 3'd0, 0, 0, 24'hFFFFFF, 0, 0), 1'b1, VIS_ONE});
        // Field extremes and clamping, predicted
        rows.push_back('{make_req(OP_HARD, 3'd1, -131072, 131071, 24'h800000, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_PCF, 3'd5, 131071, 131071, 24'h000001, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_PCF, 3'd0, -131072, -131072, 24'hFFFFFE, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_POISSON, 3'd0, 0, 0, 24'h7FFFFF, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_POISSON, 3'd3, 65536, 65536, 24'h400000, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_PPCF, 3'd1, 32768, 16384, 24'h800000, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_PPCF, 3'd2, -1, 65535, 24'hAAAAAA, 0, 0), 1'b0, '0});
        rows.push_back('{make_req(OP_HARD, 3'd4, 511, 65024, 24'h555555, 0, 0), 1'b0, '0});
        foreach (rows[i])
            send_request(rows[i].req, rows[i].fixed, rows[i].vis);
        drain();

        // Random phases, one register setting each
        per_phase = RANDOM_ITEMS / 8;
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_MAP_WIDTH, phase_cfg[p][0]);
            write_reg(CFG_MAP_HEIGHT, phase_cfg[p][1]);
            write_reg(CFG_KERNEL_SIZE, phase_cfg[p][2]);
            for (int n = 0; n < per_phase; n++) begin
                calm = (p == 3) && (n >= 20) && (n < 100);
                if (p == 2 && n == 40)
                    hold_request = 1'b1;
                send_request(pick_request(), 1'b0, '0);
            end
            calm = 1'b0;
            drain();
        end

        // Let any stray result show up
        repeat (400) @(posedge i_clk);
        $display("covered: %0d results, %0d queries over all four modes, 8 register settings",
                 results_seen, queries_sent);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0 && vis_pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
